### design/edam_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edam_pkg: shared types and constants
// Sequencer states and fixed field widths for the echo distance filter.
// ----------------------------------------------------------------------------
package edam_pkg;
    localparam int ECHO_W = 16;
    localparam int DIST_W = 11;
    localparam int DIST_MUL = 343;
    localparam int DIST_DIV = 20000;
    // floor(e*343/20000) equals (e*DIST_RECIP) >> DIST_SHIFT for every 16-bit e
    localparam int DIST_RECIP = 36829345;
    localparam int DIST_SHIFT = 31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_READ,
        S_UPD,
        S_WORK,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

### design/edam_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edam_div: restoring divider
// Unsigned division, one quotient bit per cycle, for the moving average.
// ----------------------------------------------------------------------------
module edam_div #(
    parameter int NUM_W = 14,
    parameter int DEN_W = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot, n_quot;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   trial;

    // Shift in the next numerator bit and try a subtract
    always_comb begin
        trial  = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};
        n_quot = {r_quot[NUM_W-2:0], 1'b0};
        n_rem  = trial;
        if (trial >= {1'b0, r_den}) begin
            n_rem     = trial - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_quot = r_quot;
endmodule
`default_nettype wire

### design/echo_distance_average_median.sv
`default_nettype none
// ----------------------------------------------------------------------------
// echo_distance_average_median: echo distance with moving average and median
// Converts an echo width in microseconds to centimetres and filters it.
// ----------------------------------------------------------------------------
// Input beats on s_axis carry the echo width (tdata[15:0]). Each input beat
// gives exactly one output beat on m_axis holding distance, average and
// median. One item is processed at a time: after acceptance the block
// converts the width by a reciprocal multiply, reads the oldest average
// sample from its ring memory, updates the rings, then runs a serial divider
// (one quotient bit per cycle) while a single compare unit finds the median
// by counting ranks, one window entry per cycle. The output beat waits until
// both the divider and the rank search have finished, and the next input is
// taken in the cycle after the result is loaded. A stalled result waits in
// the output register; the next item is still accepted and processed, then
// holds until the register frees, and the input stalls meanwhile.
// Reset clears positions, sum and the median window to zero; the average
// ring memory is not cleared and its contents are only used after being
// written.
// ----------------------------------------------------------------------------
module echo_distance_average_median #(
    parameter int AVG_WINDOW    = 8,
    parameter int MEDIAN_WINDOW = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] echo_us
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // [10:0] distance_cm,
                                             // [21:11] average_cm,
                                             // [32:22] median_cm, rest zero
);
    import edam_pkg::*;

    localparam int AP_W  = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int DEN_W = $clog2(AVG_WINDOW + 1);
    localparam int SUM_W = $clog2(AVG_WINDOW * 1123 + 1);
    localparam int MP_W  = (MEDIAN_WINDOW > 1) ? $clog2(MEDIAN_WINDOW) : 1;
    localparam int MC_W  = $clog2(MEDIAN_WINDOW + 1);
    localparam int PROD_W = ECHO_W + 26;

    t_state r_state, n_state;

    // Average ring memory, registered read
    logic [DIST_W-1:0] mem_avg [AVG_WINDOW];
    logic [DIST_W-1:0] r_old;

    logic [AP_W-1:0]   r_avg_pos;
    logic              r_avg_full;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  sum_next;
    logic [DIST_W-1:0] r_med [MEDIAN_WINDOW];
    logic [MP_W-1:0]   r_med_pos;

    logic [ECHO_W-1:0] r_echo;
    logic [PROD_W-1:0] r_prod;
    logic [DIST_W-1:0] r_dist;
    logic [DEN_W-1:0]  r_den;

    // Rank search
    logic [MP_W-1:0]   r_mi, r_mj;
    logic [MC_W-1:0]   r_less, r_leq;
    logic [DIST_W-1:0] r_medv;
    logic              r_med_done;

    logic              div_start, div_done;
    logic [SUM_W-1:0]  div_quot;
    logic              r_div_done;
    logic [DIST_W-1:0] r_avg;

    logic [DIST_W-1:0] r_o_dist, r_o_avg, r_o_med;
    logic              r_o_valid;
    logic              out_free;

    logic [DIST_W-1:0] cand, other;
    logic              last_j, last_i;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {7'd0, r_o_med, r_o_avg, r_o_dist};
    assign out_free      = !r_o_valid || m_axis_tready;

    // New running sum: add the fresh distance, drop the oldest once full
    assign sum_next = r_avg_full ? r_sum + SUM_W'(r_dist) - SUM_W'(r_old)
                                 : r_sum + SUM_W'(r_dist);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) n_state = S_CONV;
            S_CONV: n_state = S_READ;
            S_READ: n_state = S_UPD;
            S_UPD:  n_state = S_WORK;
            S_WORK: if (r_div_done && r_med_done) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        div_start = (r_state == S_UPD);
    end

    assign cand   = r_med[r_mi];
    assign other  = r_med[r_mj];
    assign last_j = (r_mj == MP_W'(MEDIAN_WINDOW - 1));
    assign last_i = (r_mi == MP_W'(MEDIAN_WINDOW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_avg_pos  <= '0;
            r_avg_full <= 1'b0;
            r_sum      <= '0;
            r_med_pos  <= '0;
            r_o_valid  <= 1'b0;
            r_med_done <= 1'b0;
            r_div_done <= 1'b0;
            for (int k = 0; k < MEDIAN_WINDOW; k++) r_med[k] <= '0;
        end else begin
            r_state <= n_state;
            // Load a result when the register frees, drop it once taken
            if (r_state == S_OUT && out_free) r_o_valid <= 1'b1;
            else if (m_axis_tready) r_o_valid <= 1'b0;
            case (r_state)
                S_UPD: begin
                    // Push the new distance into both rings
                    r_sum <= sum_next;
                    if (r_avg_pos == AP_W'(AVG_WINDOW - 1)) begin
                        r_avg_pos  <= '0;
                        r_avg_full <= 1'b1;
                    end else begin
                        r_avg_pos <= r_avg_pos + 1'b1;
                    end
                    r_med[r_med_pos] <= r_dist;
                    if (r_med_pos == MP_W'(MEDIAN_WINDOW - 1)) r_med_pos <= '0;
                    else r_med_pos <= r_med_pos + 1'b1;
                    r_med_done <= 1'b0;
                    r_div_done <= 1'b0;
                end
                S_WORK: begin
                    if (div_done) r_div_done <= 1'b1;
                    if (!r_med_done && last_j) begin
                        // Candidate is the median when rank fits index N/2
                        if (r_less + MC_W'(other < cand) <= MC_W'(MEDIAN_WINDOW / 2) &&
                            r_leq + MC_W'(other <= cand) > MC_W'(MEDIAN_WINDOW / 2))
                            r_med_done <= 1'b1;
                        else if (last_i)
                            r_med_done <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) r_echo <= s_axis_tdata;
            S_CONV: r_prod <= PROD_W'(r_echo) * PROD_W'(DIST_RECIP);
            S_READ: begin
                r_dist <= r_prod[DIST_SHIFT +: DIST_W];
                r_old  <= mem_avg[r_avg_pos];
                r_den  <= r_avg_full ? DEN_W'(AVG_WINDOW)
                                     : DEN_W'(r_avg_pos) + DEN_W'(1);
            end
            S_UPD: begin
                mem_avg[r_avg_pos] <= r_dist;
                r_mi   <= '0;
                r_mj   <= '0;
                r_less <= '0;
                r_leq  <= '0;
            end
            S_WORK: begin
                if (div_done) r_avg <= DIST_W'(div_quot);
                if (!r_med_done) begin
                    if (last_j) begin
                        r_medv <= cand;
                        r_mi   <= r_mi + 1'b1;
                        r_mj   <= '0;
                        r_less <= '0;
                        r_leq  <= '0;
                    end else begin
                        r_mj   <= r_mj + 1'b1;
                        r_less <= r_less + MC_W'(other < cand);
                        r_leq  <= r_leq + MC_W'(other <= cand);
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_o_dist <= r_dist;
                    r_o_avg  <= r_avg;
                    r_o_med  <= r_medv;
                end
            end
            default: ;
        endcase
    end

    edam_div #(
        .NUM_W(SUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (sum_next),
        .i_den  (r_den),
        .o_done (div_done),
        .o_quot (div_quot)
    );
endmodule
`default_nettype wire

### sim/echo_distance_average_median_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// echo_distance_average_median_tb: self-checking bench for the echo filter
// Sends echo widths over the input stream and compares each output beat with
// a predicted distance, moving average and sliding median.
// ----------------------------------------------------------------------------
module echo_distance_average_median_tb;
    import edam_pkg::*;

    localparam int AVG_N = 8;
    localparam int MED_N = 5;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] echo_us
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [10:0] distance, [21:11] average, [32:22] median

    typedef struct packed {
        logic [DIST_W-1:0] dist_cm;
        logic [DIST_W-1:0] avg;
        logic [DIST_W-1:0] med;
    } t_filt_res;

    // filter state copy
    logic [DIST_W-1:0] avg_hist [AVG_N];
    logic [DIST_W-1:0] med_hist [MED_N];
    int unsigned       avg_wr;
    bit                avg_wrapped;
    int unsigned       avg_total;
    int unsigned       med_wr;

    t_filt_res   pending_q [$];
    int          err_cnt;
    bit          hold_off;
    int          hold_cycles;

    echo_distance_average_median DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Work out the filter outputs for one echo and advance the state
    function automatic t_filt_res filter_echo(input logic [15:0] echo);
        t_filt_res r;
        int unsigned d;
        int unsigned srt [MED_N];
        int unsigned t;
        d = (int'(echo) * DIST_MUL) / DIST_DIV;
        if (avg_wr >= AVG_N) begin
            avg_wr = 0;
            avg_wrapped = 1'b1;
        end
        avg_total += d;
        if (avg_wrapped) begin
            avg_total -= avg_hist[avg_wr];
            r.avg = DIST_W'(avg_total / AVG_N);
        end else begin
            r.avg = DIST_W'(avg_total / (avg_wr + 1));
        end
        avg_hist[avg_wr] = DIST_W'(d);
        avg_wr++;
        if (med_wr >= MED_N) med_wr = 0;
        med_hist[med_wr] = DIST_W'(d);
        med_wr++;
        for (int i = 0; i < MED_N; i++) srt[i] = med_hist[i];
        for (int i = 0; i < MED_N - 1; i++) begin
            for (int j = 0; j < MED_N - 1 - i; j++) begin
                if (srt[j] > srt[j+1]) begin
                    t = srt[j];
                    srt[j] = srt[j+1];
                    srt[j+1] = t;
                end
            end
        end
        r.dist_cm = DIST_W'(d);
        r.med = DIST_W'(srt[MED_N/2]);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        err_cnt++;
    endtask

    // Offer one echo beat after a random gap and hold until accepted
    task automatic send_echo(input logic [15:0] echo);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        // Drop valid over the gap, keep it up for a back-to-back offer
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= echo;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_q.push_back(filter_echo(echo));
    endtask

    task automatic drain_results();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Check each accepted output beat against the oldest prediction
    always @(posedge i_clk) begin
        t_filt_res w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                w = pending_q.pop_front();
                if (m_axis_tdata[10:0] !== w.dist_cm)
                    report_mismatch("distance", int'(m_axis_tdata[10:0]), int'(w.dist_cm));
                if (m_axis_tdata[21:11] !== w.avg)
                    report_mismatch("average", int'(m_axis_tdata[21:11]), int'(w.avg));
                if (m_axis_tdata[32:22] !== w.med)
                    report_mismatch("median", int'(m_axis_tdata[32:22]), int'(w.med));
                if (m_axis_tdata[39:33] !== 7'd0)
                    report_mismatch("padding", int'(m_axis_tdata[39:33]), 0);
            end
        end
    end

    // Receiver stalls: random gaps, or a long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_off) begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            hold_cycles <= 0;
            if ($urandom_range(0, 19) == 0) begin
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                m_axis_tready <= ~m_axis_tready;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        logic [15:0] vals [$];
        vals = {16'd0, 16'd65535, 16'd1, 16'd58, 16'd59, 16'd32768, 16'd65534, 16'd0,
                16'd100, 16'd65535, 16'd12345, 16'd0, 16'h5555, 16'hAAAA, 16'h00FF,
                16'hFF00, 16'd2000, 16'd2000, 16'd2000, 16'd40000};
        foreach (vals[i]) send_echo(vals[i]);
        s_axis_tvalid <= 1'b0;
        drain_results();
    endtask

    task automatic test_backpressure();
        hold_off <= 1'b1;
        fork
            begin
                for (int i = 0; i < 6; i++) send_echo(16'($urandom_range(0, 65535)));
                s_axis_tvalid <= 1'b0;
            end
            begin
                @(posedge i_clk);
                while (hold_cycles < 300) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join
        drain_results();
    endtask

    task automatic test_random();
        logic [15:0] e;
        for (int i = 0; i < 720; i++) begin
            case ($urandom_range(0, 4))
                0:       e = 16'($urandom_range(0, 65535));
                1:       e = 16'($urandom_range(0, 3000));
                2:       e = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'hFFFF;
                default: e = 16'(20000 + $urandom_range(0, 600));
            endcase
            send_echo(e);
        end
        s_axis_tvalid <= 1'b0;
        drain_results();
    endtask

    initial begin
        err_cnt = 0;
        hold_off = 1'b0;
        avg_wr = 0;
        avg_wrapped = 1'b0;
        avg_total = 0;
        med_wr = 0;
        foreach (avg_hist[i]) avg_hist[i] = '0;
        foreach (med_hist[i]) med_hist[i] = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        if (err_cnt == 0) begin
            $display("echo_distance_average_median test passed");
        end else begin
            $display("echo_distance_average_median test failed");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("echo_distance_average_median test failed");
        $finish;
    end
endmodule
`default_nettype wire
